[hw/rtl/sds_pkg.sv]
// Shared constants and types for the sleep detection and scoring block.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sds_pkg;

  // Field widths
  localparam int HR_W     = 8;
  localparam int THR_W    = 15;
  localparam int PER_W    = 9;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SCORE_W  = 7;
  localparam int DAYIDX_W = 4;
  localparam int DAYPER_W = 9;

  // Internal datapath widths (asleep samples never exceed 15 bits of magnitude,
  // at most 511 of them are summed)
  localparam int SUM_W  = 25;
  localparam int QUO_W  = 24;
  localparam int SQ_W   = 48;
  localparam int ROOT_W = 24;
  localparam int DIV_W  = 48;
  localparam int PEN_W  = 27;
  localparam int SC_W   = 18;
  localparam int SSUM_W = 48;
  localparam int SCNT_W = 32;

  // Score constants: full score in units of 1/2560, maximum in whole points
  localparam logic [PEN_W-1:0]    SCORE_FULL = PEN_W'(256000);
  localparam logic [SCORE_W-1:0]  SCORE_MAX  = SCORE_W'(100);
  localparam logic [DAYPER_W-1:0] DAYPER_MAX = DAYPER_W'(511);

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam logic [2:0] REG_MIN_HR   = 3'd0;
  localparam logic [2:0] REG_MAX_HR   = 3'd1;
  localparam logic [2:0] REG_MOTION   = 3'd2;
  localparam logic [2:0] REG_PERIOD   = 3'd3;
  localparam logic [2:0] REG_REST_HR  = 3'd4;
  localparam logic [2:0] REG_ROLLOVER = 3'd5;

  // Reset values of the registers
  localparam logic [HR_W-1:0]   RST_MIN_HR   = HR_W'(50);
  localparam logic [HR_W-1:0]   RST_MAX_HR   = HR_W'(80);
  localparam logic [THR_W-1:0]  RST_MOTION   = THR_W'(5);
  localparam logic [PER_W-1:0]  RST_PERIOD   = PER_W'(300);
  localparam logic [HR_W-1:0]   RST_REST_HR  = HR_W'(60);
  localparam logic [HOUR_W-1:0] RST_ROLLOVER = HOUR_W'(9);

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[hw/rtl/sds_if.sv]
// Valid/ready channels of the sleep scoring block: sample input and result output.
// Depends on sds_pkg for field widths.
`timescale 1ns / 1ps

interface sds_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                                 valid;
  logic                                 ready;
  logic        [sds_pkg::HR_W-1:0]      heart_rate;
  logic signed [SAMPLE_BITS-1:0]        accel_x;
  logic signed [SAMPLE_BITS-1:0]        accel_y;
  logic signed [SAMPLE_BITS-1:0]        accel_z;
  logic signed [SAMPLE_BITS-1:0]        gyro_x;
  logic signed [SAMPLE_BITS-1:0]        gyro_y;
  logic signed [SAMPLE_BITS-1:0]        gyro_z;
  logic        [sds_pkg::HOUR_W-1:0]    hour;
  logic        [sds_pkg::MIN_W-1:0]     minute;
  logic        [sds_pkg::MIN_W-1:0]     second;

  modport source (output valid, heart_rate, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, hour, minute, second, input ready);
  modport sink   (input valid, heart_rate, accel_x, accel_y, accel_z,
                  gyro_x, gyro_y, gyro_z, hour, minute, second, output ready);
endinterface

interface sds_result_if;
  logic                             valid;
  logic                             ready;
  logic                             asleep;
  logic                             period_done;
  logic [sds_pkg::SCORE_W-1:0]      period_score;
  logic [sds_pkg::SCORE_W-1:0]      blended_quality;
  logic [sds_pkg::DAYIDX_W-1:0]     day_index;
  logic [sds_pkg::DAYPER_W-1:0]     day_periods;

  modport source (output valid, asleep, period_done, period_score, blended_quality,
                  day_index, day_periods, input ready);
  modport sink   (input valid, asleep, period_done, period_score, blended_quality,
                  day_index, day_periods, output ready);
endinterface

[hw/rtl/sds_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, WIDTH quotient bits per divide.
// Depends on sds_pkg for the unit status struct.
`timescale 1ns / 1ps

module sds_div #(
  parameter int WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output logic [WIDTH-1:0]    quotient,
  output sds_pkg::unit_stat_t stat
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH:0]     rem;
  logic [WIDTH-1:0]   quo;
  logic [WIDTH-1:0]   dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [WIDTH:0]     rem_sh;
  logic               ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem[WIDTH-1:0], quo[WIDTH-1]};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[WIDTH-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hw/rtl/sds_sqrt.sv]
// Digit-serial integer square root: two radicand bits per cycle.
// Depends on sds_pkg for the unit status struct.
`timescale 1ns / 1ps

module sds_sqrt #(
  parameter int WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WIDTH-1:0]     radicand,
  output logic [WIDTH/2-1:0]   root,
  output sds_pkg::unit_stat_t  stat
);

  localparam int HW    = WIDTH / 2;
  localparam int RW    = HW + 3;
  localparam int CNT_W = (HW > 1) ? $clog2(HW) : 1;

  logic [WIDTH-1:0] rad;
  logic [RW-1:0]    rem;
  logic [HW-1:0]    rt;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             ge;

  // Bring down the next bit pair and test root*4+1
  always_comb begin
    rem_sh = {rem[RW-3:0], rad[WIDTH-1:WIDTH-2]};
    trial  = RW'({rt, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(HW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (busy) begin
      rad <= {rad[WIDTH-3:0], 2'b00};
      rem <= ge ? (rem_sh - trial) : rem_sh;
      rt  <= {rt[HW-2:0], ge};
    end
  end

  assign root      = rt;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hw/rtl/sleep_detect_and_score.sv]
// Top level of the sleep detection and scoring block.
// Depends on sds_pkg, sds_if (channels), sds_div and sds_sqrt.
//
// Usage:
//   samples : one item per one-second sample (heart rate, six motion axes, time).
//   scores  : one item per sample: asleep flag, period close flag, lifetime mean
//             score, blended quality, day slot and periods in that slot.
//   APB     : six registers at byte addresses 0,4,..,20; the user must write
//             them only while idle, which the block does not enforce.
// Sequence: an item that does not close a period passes the classify, read and
//   output states. An item that closes a period also runs six bit-serial
//   divides and squarings, two square roots and the mean divide.
// One item is processed at a time; samples.ready is high while the sequencer is
//   idle, also while a finished result still waits in the output register.
// A stalled receiver holds the result register; the next result waits for it.
// Reset (synchronous, active high) restores register defaults and clears all
//   sums, counters, the day slot and every per-day count (valid bits).
`timescale 1ns / 1ps

module sleep_detect_and_score #(
  parameter int DAY_SLOTS   = 12,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  sds_sample_if.sink                          samples,
  sds_result_if.source                        scores,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sds_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [sds_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [sds_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int SLOT_W = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
  localparam int MAGC_W = sds_pkg::SUM_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLASS     = 4'd1;
  localparam logic [3:0] S_READ      = 4'd2;
  localparam logic [3:0] S_DIV_GO    = 4'd3;
  localparam logic [3:0] S_DIV_WAIT  = 4'd4;
  localparam logic [3:0] S_MUL       = 4'd5;
  localparam logic [3:0] S_SQ_GO     = 4'd6;
  localparam logic [3:0] S_SQ_WAIT   = 4'd7;
  localparam logic [3:0] S_SCORE     = 4'd8;
  localparam logic [3:0] S_MEAN_GO   = 4'd9;
  localparam logic [3:0] S_MEAN_WAIT = 4'd10;
  localparam logic [3:0] S_FIN       = 4'd11;
  localparam logic [3:0] S_OUT       = 4'd12;

  // Configuration registers
  logic [sds_pkg::HR_W-1:0]   min_hr;
  logic [sds_pkg::HR_W-1:0]   max_hr;
  logic [sds_pkg::THR_W-1:0]  motion_thr;
  logic [sds_pkg::PER_W-1:0]  period;
  logic [sds_pkg::HR_W-1:0]   rest_hr;
  logic [sds_pkg::HOUR_W-1:0] roll_hour;

  // Sequencer and state
  logic [3:0]                        state;
  logic [sds_pkg::HR_W-1:0]          hr_q;
  logic signed [SAMPLE_BITS-1:0]     axis_q [6];
  logic                              roll_q;
  logic                              asleep_q;
  logic                              done_q;
  logic [sds_pkg::PER_W-1:0]         cnt;
  logic signed [sds_pkg::SUM_W-1:0]  sums [6];
  logic [SLOT_W-1:0]                 slot;
  logic [sds_pkg::SCORE_W-1:0]       blended;
  logic [sds_pkg::SSUM_W-1:0]        score_sum;
  logic [sds_pkg::SCNT_W-1:0]        score_cnt;
  logic [sds_pkg::SCORE_W-1:0]       mean;
  logic [2:0]                        axis;
  logic [sds_pkg::SQ_W-1:0]          sa;
  logic [sds_pkg::SQ_W-1:0]          sg;
  logic [sds_pkg::SQ_W-1:0]          mul_a;
  logic [sds_pkg::QUO_W-1:0]         mul_b;
  logic [$clog2(sds_pkg::QUO_W)-1:0] mul_cnt;
  logic                              sq_g;
  logic [sds_pkg::ROOT_W-1:0]        ma;
  logic [sds_pkg::ROOT_W-1:0]        mg;

  // Per-day period counts
  logic [sds_pkg::DAYPER_W-1:0]      ppd [DAY_SLOTS];
  logic [DAY_SLOTS-1:0]              ppd_vld;
  logic [sds_pkg::DAYPER_W-1:0]      ppd_rd;

  // Serial units
  logic                              div_start;
  logic [sds_pkg::DIV_W-1:0]         div_dividend;
  logic [sds_pkg::DIV_W-1:0]         div_divisor;
  logic [sds_pkg::DIV_W-1:0]         div_quo;
  sds_pkg::unit_stat_t               div_stat;
  logic                              sq_start;
  logic [sds_pkg::SQ_W-1:0]          sq_rad;
  logic [sds_pkg::ROOT_W-1:0]        sq_root;
  sds_pkg::unit_stat_t               sq_stat;

  // Combinational helpers
  logic signed [SAMPLE_BITS-1:0]     in_axis [6];
  logic [SAMPLE_BITS-1:0]            in_mag;
  logic                              still;
  logic                              asleep_c;
  logic                              roll_c;
  logic [sds_pkg::PER_W-1:0]         cnt_next;
  logic [sds_pkg::PER_W-1:0]         period_eff;
  logic                              close;
  logic [SLOT_W-1:0]                 slot_next;
  logic signed [sds_pkg::SUM_W-1:0]  sum_sel;
  logic [sds_pkg::SUM_W-1:0]         sum_neg;
  logic [sds_pkg::QUO_W-1:0]         sum_abs;
  logic [sds_pkg::HR_W-1:0]          dev;
  logic [sds_pkg::PEN_W-1:0]         pen;
  logic [sds_pkg::SC_W-1:0]          s_val;
  logic [sds_pkg::SSUM_W:0]          ssum_next;
  logic [sds_pkg::SCNT_W+11:0]       score_div;
  logic [sds_pkg::SCORE_W:0]         blend_sum;
  logic                              acc_ok;
  logic                              in_fire;
  logic                              cfg_wr;
  logic [SLOT_W+sds_pkg::DAYIDX_W-1:0] slot_ext;

  assign in_axis[0] = samples.accel_x;
  assign in_axis[1] = samples.accel_y;
  assign in_axis[2] = samples.accel_z;
  assign in_axis[3] = samples.gyro_x;
  assign in_axis[4] = samples.gyro_y;
  assign in_axis[5] = samples.gyro_z;

  // Sample classification and rollover detect at accept
  always_comb begin
    still = 1'b1;
    in_mag = '0;
    for (int i = 0; i < 6; i++) begin
      in_mag = in_axis[i][SAMPLE_BITS-1] ? (~in_axis[i] + 1'b1) : in_axis[i];
      if (MAGC_W'(in_mag) > MAGC_W'(motion_thr)) still = 1'b0;
    end
    asleep_c = still && (samples.heart_rate >= min_hr) && (samples.heart_rate <= max_hr);
    roll_c   = (samples.hour == roll_hour) && (samples.minute == '0) &&
               (samples.second == '0);
  end

  assign in_fire         = samples.valid && samples.ready;
  assign samples.ready   = (state == S_IDLE);

  // Period count and close test
  always_comb begin
    cnt_next   = asleep_q ? (cnt + 1'b1) : cnt;
    period_eff = (period == '0) ? sds_pkg::PER_W'(1) : period;
    close      = (cnt_next >= period_eff) && (cnt_next != '0);
    slot_next  = (slot == SLOT_W'(DAY_SLOTS - 1)) ? '0 : (slot + 1'b1);
  end

  // Magnitude of the selected axis sum
  always_comb begin
    sum_sel = sums[axis];
    sum_neg = sds_pkg::SUM_W'(-sum_sel);
    sum_abs = sum_sel[sds_pkg::SUM_W-1] ? sum_neg[sds_pkg::QUO_W-1:0]
                                        : sum_sel[sds_pkg::QUO_W-1:0];
  end

  // Divider and root operands
  always_comb begin
    score_div = {score_cnt, 11'b0} + {2'b00, score_cnt, 9'b0} + '0;
    div_start = (state == S_DIV_GO) || (state == S_MEAN_GO);
    if (state == S_MEAN_GO) begin
      div_dividend = score_sum;
      div_divisor  = sds_pkg::DIV_W'(score_div);
    end else if (axis < 3'd3) begin
      div_dividend = sds_pkg::DIV_W'({sum_abs, 8'b0});
      div_divisor  = sds_pkg::DIV_W'(cnt);
    end else begin
      div_dividend = sds_pkg::DIV_W'(sum_abs);
      div_divisor  = sds_pkg::DIV_W'(cnt);
    end
    sq_start = (state == S_SQ_GO);
    sq_rad   = sq_g ? {sg[sds_pkg::SQ_W-17:0], 16'b0} : sa;
  end

  // Score from the two magnitudes and the heart-rate deviation
  always_comb begin
    dev       = (hr_q > rest_hr) ? (hr_q - rest_hr) : (rest_hr - hr_q);
    pen       = sds_pkg::PEN_W'({ma, 1'b0}) + sds_pkg::PEN_W'({dev, 10'b0}) +
                sds_pkg::PEN_W'({dev, 8'b0}) + sds_pkg::PEN_W'({mg, 1'b0}) +
                sds_pkg::PEN_W'(mg);
    s_val     = (pen >= sds_pkg::SCORE_FULL) ? '0
                                             : sds_pkg::SC_W'(sds_pkg::SCORE_FULL - pen);
    ssum_next = {1'b0, score_sum} + (sds_pkg::SSUM_W + 1)'(s_val);
    acc_ok    = (score_cnt != '1) && !ssum_next[sds_pkg::SSUM_W];
    blend_sum = {1'b0, blended} + {1'b0, mean};
  end

  sds_div #(.WIDTH(sds_pkg::DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  sds_sqrt #(.WIDTH(sds_pkg::SQ_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  // Configuration writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_hr     <= sds_pkg::RST_MIN_HR;
      max_hr     <= sds_pkg::RST_MAX_HR;
      motion_thr <= sds_pkg::RST_MOTION;
      period     <= sds_pkg::RST_PERIOD;
      rest_hr    <= sds_pkg::RST_REST_HR;
      roll_hour  <= sds_pkg::RST_ROLLOVER;
    end else if (cfg_wr) begin
      case (paddr[sds_pkg::APB_ADDR_W-1:2])
        sds_pkg::REG_MIN_HR:   min_hr     <= pwdata[sds_pkg::HR_W-1:0];
        sds_pkg::REG_MAX_HR:   max_hr     <= pwdata[sds_pkg::HR_W-1:0];
        sds_pkg::REG_MOTION:   motion_thr <= pwdata[sds_pkg::THR_W-1:0];
        sds_pkg::REG_PERIOD:   period     <= pwdata[sds_pkg::PER_W-1:0];
        sds_pkg::REG_REST_HR:  rest_hr    <= pwdata[sds_pkg::HR_W-1:0];
        sds_pkg::REG_ROLLOVER: roll_hour  <= pwdata[sds_pkg::HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[sds_pkg::APB_ADDR_W-1:2])
      sds_pkg::REG_MIN_HR:   prdata = sds_pkg::APB_DATA_W'(min_hr);
      sds_pkg::REG_MAX_HR:   prdata = sds_pkg::APB_DATA_W'(max_hr);
      sds_pkg::REG_MOTION:   prdata = sds_pkg::APB_DATA_W'(motion_thr);
      sds_pkg::REG_PERIOD:   prdata = sds_pkg::APB_DATA_W'(period);
      sds_pkg::REG_REST_HR:  prdata = sds_pkg::APB_DATA_W'(rest_hr);
      sds_pkg::REG_ROLLOVER: prdata = sds_pkg::APB_DATA_W'(roll_hour);
      default:               prdata = '0;
    endcase
  end

  // Input capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hr_q     <= samples.heart_rate;
      axis_q   <= in_axis;
      roll_q   <= roll_c;
      asleep_q <= asleep_c;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      for (int i = 0; i < 6; i++) sums[i] <= '0;
      slot      <= '0;
      blended   <= '0;
      score_sum <= '0;
      score_cnt <= '0;
      done_q    <= 1'b0;
      axis      <= '0;
      sq_g      <= 1'b0;
      mul_cnt   <= '0;
      mean      <= '0;
      ppd_vld   <= '0;
      scores.valid <= 1'b0;
    end else begin
      if (scores.valid && scores.ready) scores.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) state <= S_CLASS;
        end
        S_CLASS: begin
          if (roll_q) begin
            slot    <= slot_next;
            blended <= '0;
          end
          cnt <= cnt_next;
          if (asleep_q) begin
            for (int i = 0; i < 6; i++) begin
              sums[i] <= sums[i] + sds_pkg::SUM_W'(axis_q[i]);
            end
          end
          done_q <= close;
          mean   <= '0;
          state  <= S_READ;
        end
        S_READ: begin
          axis <= '0;
          sa   <= '0;
          sg   <= '0;
          sq_g <= 1'b0;
          state <= done_q ? S_DIV_GO : S_OUT;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            mul_a   <= sds_pkg::SQ_W'(div_quo[sds_pkg::QUO_W-1:0]);
            mul_b   <= div_quo[sds_pkg::QUO_W-1:0];
            mul_cnt <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          // One multiplier bit per cycle into the accel or gyro sum of squares
          if (mul_b[0]) begin
            if (axis < 3'd3) sa <= sa + mul_a;
            else             sg <= sg + mul_a;
          end
          mul_a   <= {mul_a[sds_pkg::SQ_W-2:0], 1'b0};
          mul_b   <= {1'b0, mul_b[sds_pkg::QUO_W-1:1]};
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == $bits(mul_cnt)'(sds_pkg::QUO_W - 1)) begin
            if (axis == 3'd5) begin
              state <= S_SQ_GO;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_stat.done) begin
            if (sq_g) begin
              mg    <= sq_root;
              state <= S_SCORE;
            end else begin
              ma    <= sq_root;
              sq_g  <= 1'b1;
              state <= S_SQ_GO;
            end
          end
        end
        S_SCORE: begin
          if (acc_ok) begin
            score_sum <= ssum_next[sds_pkg::SSUM_W-1:0];
            score_cnt <= score_cnt + 1'b1;
          end
          state <= S_MEAN_GO;
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_stat.done) begin
            if (score_cnt == '0)
              mean <= '0;
            else if (div_quo > sds_pkg::DIV_W'(sds_pkg::SCORE_MAX))
              mean <= sds_pkg::SCORE_MAX;
            else
              mean <= div_quo[sds_pkg::SCORE_W-1:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          blended <= blend_sum[sds_pkg::SCORE_W:1];
          cnt     <= '0;
          for (int i = 0; i < 6; i++) sums[i] <= '0;
          ppd_vld[slot] <= 1'b1;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!scores.valid || scores.ready) begin
            scores.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-day count store: read after rollover, written back when a period closes
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      ppd_rd <= ppd_vld[slot] ? ppd[slot] : '0;
    end else if (state == S_FIN) begin
      if (ppd_rd < sds_pkg::DAYPER_MAX) begin
        ppd[slot] <= ppd_rd + 1'b1;
        ppd_rd    <= ppd_rd + 1'b1;
      end else begin
        ppd[slot] <= ppd_rd;
      end
    end
  end

  // Result register payload
  assign slot_ext = {{sds_pkg::DAYIDX_W{1'b0}}, slot};

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!scores.valid || scores.ready)) begin
      scores.asleep          <= asleep_q;
      scores.period_done     <= done_q;
      scores.period_score    <= mean;
      scores.blended_quality <= blended;
      scores.day_index       <= slot_ext[sds_pkg::DAYIDX_W-1:0];
      scores.day_periods     <= ppd_rd;
    end
  end

  // Assertions
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(DAY_SLOTS - 1))
    else $error("day slot out of range");

  a_score_zero: assert property (@(posedge clk) disable iff (rst)
    scores.valid && !scores.period_done |-> scores.period_score == '0)
    else $error("score reported without a closed period");

  a_score_max: assert property (@(posedge clk) disable iff (rst)
    scores.valid |-> (scores.period_score <= sds_pkg::SCORE_MAX) &&
                     (scores.blended_quality <= sds_pkg::SCORE_MAX))
    else $error("score above 100");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_CLASS)
    else $error("accepted item not started");

endmodule

[sim/tb_sleep_detect_and_score.sv]
// Self-checking testbench for sleep_detect_and_score: random and directed samples,
// APB register phases, and a scoreboard that predicts every result item.
// Depends on sds_pkg, sds_if and the block's RTL.
`timescale 1ns / 1ps

module tb_sleep_detect_and_score;
  import sds_pkg::*;

  localparam int NUM_SLOTS  = 12;
  localparam int STALL_MAX  = 13;
  localparam int IDLE_LIMIT = 6000;

  typedef struct {
    logic [HR_W-1:0]   hr;
    logic [15:0]       acc [3];
    logic [15:0]       gyr [3];
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [MIN_W-1:0]  second;
  } sample_t;

  typedef struct packed {
    logic                asleep;
    logic                done;
    logic [SCORE_W-1:0]  score;
    logic [SCORE_W-1:0]  blended;
    logic [DAYIDX_W-1:0] day;
    logic [DAYPER_W-1:0] day_per;
  } outcome_t;

  // Sleep scoring predictor plus the queue of outcomes it expects
  class sleep_scoreboard;
    logic [HR_W-1:0]   min_hr, max_hr, rest_hr;
    logic [THR_W-1:0]  motion;
    logic [PER_W-1:0]  per_len;
    logic [HOUR_W-1:0] roll_hour;
    int unsigned       asleep_cnt;
    longint            acc_sum [3];
    longint            gyr_sum [3];
    longint unsigned   score_sum;
    longint unsigned   score_cnt;
    int unsigned       blend;
    int unsigned       slot;
    int unsigned       day_count [NUM_SLOTS];
    outcome_t          pending_q [$];
    int                errors;

    function new();
      min_hr = RST_MIN_HR; max_hr = RST_MAX_HR; motion = RST_MOTION;
      per_len = RST_PERIOD; rest_hr = RST_REST_HR; roll_hour = RST_ROLLOVER;
      asleep_cnt = 0; score_sum = 0; score_cnt = 0; blend = 0; slot = 0;
      for (int i = 0; i < 3; i++) begin
        acc_sum[i] = 0;
        gyr_sum[i] = 0;
      end
      foreach (day_count[i]) day_count[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MIN_HR:   min_hr = val[HR_W-1:0];
        REG_MAX_HR:   max_hr = val[HR_W-1:0];
        REG_MOTION:   motion = val[THR_W-1:0];
        REG_PERIOD:   per_len = val[PER_W-1:0];
        REG_REST_HR:  rest_hr = val[HR_W-1:0];
        REG_ROLLOVER: roll_hour = val[HOUR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_sample(sample_t s);
      outcome_t        o;
      int unsigned     period;
      int              v;
      longint          a, g;
      longint unsigned sa, sg, ma, mg, dev, pen, sc, mean;
      o = '0;
      period = (per_len == 0) ? 1 : per_len;
      // rollover first, then classification, then period close
      if (s.hour == roll_hour && s.minute == 0 && s.second == 0) begin
        slot = (slot + 1) % NUM_SLOTS;
        blend = 0;
      end
      o.asleep = (s.hr >= min_hr) && (s.hr <= max_hr);
      for (int i = 0; i < 3; i++) begin
        v = $signed(s.acc[i]);
        if ((v < 0 ? -v : v) > motion) o.asleep = 0;
        v = $signed(s.gyr[i]);
        if ((v < 0 ? -v : v) > motion) o.asleep = 0;
      end
      if (o.asleep) begin
        asleep_cnt = (asleep_cnt + 1) & 9'h1FF;
        for (int i = 0; i < 3; i++) begin
          acc_sum[i] += longint'($signed(s.acc[i]));
          gyr_sum[i] += longint'($signed(s.gyr[i]));
        end
      end
      if (asleep_cnt >= period && asleep_cnt != 0) begin
        sa = 0;
        sg = 0;
        for (int i = 0; i < 3; i++) begin
          a = (acc_sum[i] * 256) / longint'(asleep_cnt);
          g = gyr_sum[i] / longint'(asleep_cnt);
          sa += longint'(a * a);
          sg += longint'(g * g);
        end
        ma = int_sqrt(sa);
        mg = int_sqrt(sg << 16);
        dev = (s.hr > rest_hr) ? s.hr - rest_hr : rest_hr - s.hr;
        pen = 2 * ma + 1280 * dev + 3 * mg;
        sc = (pen >= 256000) ? 0 : 256000 - pen;
        // lifetime totals stop growing once they would overflow
        if (score_cnt != 64'hFFFF_FFFF && score_sum + sc <= 64'hFFFF_FFFF_FFFF) begin
          score_sum += sc;
          score_cnt++;
        end
        mean = (score_cnt != 0) ? score_sum / (score_cnt * 2560) : 0;
        if (mean > 100) mean = 100;
        o.score = mean[SCORE_W-1:0];
        blend = (blend + int'(mean)) / 2;
        asleep_cnt = 0;
        for (int i = 0; i < 3; i++) begin
          acc_sum[i] = 0;
          gyr_sum[i] = 0;
        end
        if (day_count[slot] < 511) day_count[slot]++;
        o.done = 1;
      end
      o.blended = blend[SCORE_W-1:0];
      o.day = slot[DAYIDX_W-1:0];
      o.day_per = day_count[slot][DAYPER_W-1:0];
      pending_q.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.asleep !== want.asleep)
        $display("%0t: asleep exp %0d got %0d", $time, want.asleep, got.asleep);
      if (got.done !== want.done)
        $display("%0t: period_done exp %0d got %0d", $time, want.done, got.done);
      if (got.score !== want.score)
        $display("%0t: period_score exp %0d got %0d", $time, want.score, got.score);
      if (got.blended !== want.blended)
        $display("%0t: blended_quality exp %0d got %0d", $time, want.blended, got.blended);
      if (got.day !== want.day)
        $display("%0t: day_index exp %0d got %0d", $time, want.day, got.day);
      if (got.day_per !== want.day_per)
        $display("%0t: day_periods exp %0d got %0d", $time, want.day_per, got.day_per);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  sds_sample_if #(.SAMPLE_BITS(16)) smp ();
  sds_result_if res ();

  sleep_detect_and_score #(.DAY_SLOTS(NUM_SLOTS), .SAMPLE_BITS(16)) dut (
    .clk(clk), .rst(rst), .samples(smp), .scores(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sleep_scoreboard sb = new();
  bit in_take, out_take;
  bit quiet_tx, quiet_rx;
  int idle_cycles;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    smp.valid = 0; smp.heart_rate = '0; smp.hour = '0; smp.minute = '0; smp.second = '0;
    smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
    smp.gyro_x = '0; smp.gyro_y = '0; smp.gyro_z = '0;
    res.ready = 0;
  end

  // Result side: random stalls, check every accepted item
  always begin
    int gap;
    outcome_t got;
    gap = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      res.ready = (gap == 0);
      #1;
      out_take = res.ready && res.valid;
      got = '{res.asleep, res.period_done, res.period_score, res.blended_quality,
              res.day_index, res.day_periods};
      @(posedge clk);
      if (out_take) begin
        sb.check_result(got);
        if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
        gap = quiet_rx ? 0 : $urandom_range(0, STALL_MAX);
      end else if (gap > 0) begin
        gap--;
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    #2;
    if (rst || in_take || out_take) idle_cycles = 0;
    else idle_cycles++;
    in_take = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_sample(sample_t s);
    int gap;
    bit rdy;
    gap = quiet_tx ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      smp.valid = 0;
      repeat (gap) @(negedge clk);
    end
    smp.valid = 1;
    smp.heart_rate = s.hr; smp.hour = s.hour; smp.minute = s.minute; smp.second = s.second;
    smp.accel_x = s.acc[0]; smp.accel_y = s.acc[1]; smp.accel_z = s.acc[2];
    smp.gyro_x = s.gyr[0]; smp.gyro_y = s.gyr[1]; smp.gyro_z = s.gyr[2];
    do begin
      #1;
      rdy = smp.ready;
      @(posedge clk);
      if (rdy) begin
        in_take = 1;
        sb.note_sample(s);
      end
      @(negedge clk);
    end while (!rdy);
    if ($urandom_range(0, 49) == 0) quiet_tx = !quiet_tx;
  endtask

  // Let the block drain before touching registers
  task automatic drain();
    smp.valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic sample_t make_sample(bit calm);
    sample_t s;
    int thr;
    int r;
    thr = sb.motion;
    if (calm && sb.min_hr <= sb.max_hr) s.hr = $urandom_range(sb.min_hr, sb.max_hr);
    else s.hr = $urandom;
    for (int i = 0; i < 3; i++) begin
      s.acc[i] = calm ? 16'($urandom_range(0, 2 * thr) - thr) : 16'($urandom);
      s.gyr[i] = calm ? 16'($urandom_range(0, 2 * thr) - thr) : 16'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      s.hour = sb.roll_hour; s.minute = 0; s.second = 0;
    end else if (r < 8) begin
      s.hour = $urandom; s.minute = $urandom; s.second = $urandom;
    end else begin
      s.hour = $urandom_range(0, 23); s.minute = $urandom_range(0, 59);
      s.second = $urandom_range(1, 59);
    end
    return s;
  endfunction

  function automatic sample_t fixed_sample(int hr, int a, int g, int hh, int mm, int ss);
    sample_t s;
    s.hr = hr;
    for (int i = 0; i < 3; i++) begin
      s.acc[i] = 16'(a);
      s.gyr[i] = 16'(g);
    end
    s.hour = hh; s.minute = mm; s.second = ss;
    return s;
  endfunction

  initial begin
    logic [31:0] lo;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: band edges, motion edges, rollover and odd time with reset settings
    send_sample(fixed_sample(50, 0, 0, 1, 2, 3));
    send_sample(fixed_sample(80, 5, -5, 1, 2, 4));
    send_sample(fixed_sample(49, 0, 0, 1, 2, 5));
    send_sample(fixed_sample(81, 0, 0, 1, 2, 6));
    send_sample(fixed_sample(60, 6, 0, 1, 2, 7));
    send_sample(fixed_sample(60, -32768, 32767, 1, 2, 8));
    send_sample(fixed_sample(60, 0, -6, 1, 2, 9));
    send_sample(fixed_sample(60, -5, 5, 9, 0, 0));
    send_sample(fixed_sample(255, 0, 0, 31, 63, 63));
    send_sample(fixed_sample(0, 0, 0, 9, 0, 1));
    drain();

    // Wide-open settings; period lowered below the running count
    write_reg(REG_MIN_HR, 0);
    write_reg(REG_MAX_HR, 255);
    write_reg(REG_MOTION, 32767);
    write_reg(REG_PERIOD, 1);
    write_reg(REG_REST_HR, 255);
    write_reg(REG_ROLLOVER, 0);
    send_sample(fixed_sample(0, 32767, 32767, 5, 0, 0));
    send_sample(fixed_sample(0, -32767, -32767, 5, 0, 1));
    send_sample(fixed_sample(255, 0, 0, 0, 0, 0));
    send_sample(fixed_sample(255, 1, -1, 0, 0, 0));
    send_sample(fixed_sample(128, -32768, 0, 0, 0, 0));
    send_sample(fixed_sample(200, 100, -200, 23, 59, 59));
    drain();
    write_reg(REG_PERIOD, 0);
    write_reg(REG_ROLLOVER, 23);
    send_sample(fixed_sample(255, 32767, -32767, 23, 0, 0));
    send_sample(fixed_sample(0, 0, 0, 23, 0, 0));
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      lo = (p % 3 == 0) ? 0 : $urandom_range(0, 90);
      write_reg(REG_MIN_HR, lo);
      write_reg(REG_MAX_HR, (p % 4 == 0) ? 255 : $urandom_range(lo, 255));
      case (p % 4)
        0: write_reg(REG_MOTION, 32767);
        1: write_reg(REG_MOTION, $urandom_range(0, 300));
        2: write_reg(REG_MOTION, (p == 2) ? 0 : $urandom_range(0, 32767));
        default: write_reg(REG_MOTION, $urandom_range(0, 40));
      endcase
      case (p)
        3: write_reg(REG_PERIOD, 511);
        5: write_reg(REG_PERIOD, 0);
        6: write_reg(REG_PERIOD, 40);
        default: write_reg(REG_PERIOD, $urandom_range(1, 6));
      endcase
      write_reg(REG_REST_HR, (p == 1) ? 0 : (p == 4) ? 255 : $urandom_range(0, 255));
      write_reg(REG_ROLLOVER, (p == 2) ? 0 : (p == 5) ? 23 : $urandom_range(0, 23));
      for (int n = 0; n < 100; n++)
        send_sample(make_sample($urandom_range(0, 99) < 75));
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sds_pkg.sv
hw/rtl/sds_if.sv
hw/rtl/sds_div.sv
hw/rtl/sds_sqrt.sv
hw/rtl/sleep_detect_and_score.sv
sim/tb_sleep_detect_and_score.sv
